[src/pfa_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the prime field arithmetic unit.
// No dependencies.
package pfa_pkg;

  // Field modulus and the Fermat exponent for inversion
  localparam logic [255:0] PRIME = 256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
  localparam logic [255:0] INV_EXP = PRIME - 256'd2;
  localparam logic [255:0] FIELD_ONE = 256'd1;
  localparam logic [63:0] PRIME_L0 = PRIME[63:0];
  localparam logic [63:0] LIMB_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_INV = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_FIN,
    ST_DONE
  } back_state_e;

  // One classified request, operands already below the modulus
  typedef struct packed {
    action_e      op;
    logic [255:0] a;
    logic [255:0] b;
  } item_t;

  // Bring a 256-bit value below the modulus: one subtraction is enough
  function automatic logic [255:0] reduce_once(input logic [255:0] x);
    logic [256:0] diff;
    diff = {1'b0, x} - {1'b0, PRIME};
    reduce_once = diff[256] ? x : diff[255:0];
  endfunction

endpackage

[src/pfa_req_if.sv]
`timescale 1ns / 1ps
// Request channel: operation code and two operands as 64-bit limbs.
// No dependencies.
interface pfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] a_limb0;
  logic [63:0] a_limb1;
  logic [63:0] a_limb2;
  logic [63:0] a_limb3;
  logic [63:0] b_limb0;
  logic [63:0] b_limb1;
  logic [63:0] b_limb2;
  logic [63:0] b_limb3;

  modport source (
    output valid, action, a_limb0, a_limb1, a_limb2, a_limb3,
    output b_limb0, b_limb1, b_limb2, b_limb3,
    input  ready
  );
  modport sink (
    input  valid, action, a_limb0, a_limb1, a_limb2, a_limb3,
    input  b_limb0, b_limb1, b_limb2, b_limb3,
    output ready
  );
endinterface

[src/pfa_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel: reduced result as 64-bit limbs and a zero flag.
// No dependencies.
interface pfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] r_limb0;
  logic [63:0] r_limb1;
  logic [63:0] r_limb2;
  logic [63:0] r_limb3;
  logic        result_zero;

  modport source (
    output valid, r_limb0, r_limb1, r_limb2, r_limb3, result_zero,
    input  ready
  );
  modport sink (
    input  valid, r_limb0, r_limb1, r_limb2, r_limb3, result_zero,
    output ready
  );
endinterface

[src/prime_field_arith_unit.sv]
`timescale 1ns / 1ps
// Top level of the prime field arithmetic unit (p = 2^256 - 2^32 - 977).
// Depends on pfa_pkg, pfa_req_if, pfa_rsp_if, pfa_front, pfa_queue, pfa_back.
//
//   channel  | dir | payload                          | handshake
//   req_i    | in  | action, a_limb0..3, b_limb0..3   | valid/ready
//   rsp_o    | out | r_limb0..3, result_zero          | valid/ready
//
// In the back end, add and subtract go through the fold and final subtract steps; multiply takes
// nine passes of the 8-lane 32x32 multiplier row, repeated folds and one final subtract.
// Invert runs a square-and-multiply ladder over the 256 exponent bits, 505
// multiplications in all, and holds the back end.
// Up to two requests wait in the queue while the back end is busy; a finished result
// waits in the output register without stopping new requests. Reset is asynchronous.
module prime_field_arith_unit import pfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfa_req_if.sink   req_i,
  pfa_rsp_if.source rsp_o
);

  item_t push_item, pop_item;
  logic  push_valid, push_ready, pop_valid, pop_ready;

  pfa_front u_front (
    .req_i        (req_i),
    .push_item_o  (push_item),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  pfa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (push_item),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_item_o   (pop_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  pfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (pop_item),
    .item_valid_i (pop_valid),
    .item_ready_o (pop_ready),
    .rsp_o        (rsp_o)
  );

endmodule

[src/pfa_front.sv]
`timescale 1ns / 1ps
// Front end: accept a request, decode the operation, reduce both operands mod p.
// Depends on pfa_pkg and pfa_req_if.
module pfa_front import pfa_pkg::*; (
  pfa_req_if.sink   req_i,
  output item_t     push_item_o,
  output logic      push_valid_o,
  input  logic      push_ready_i
);

  // Accept whenever the queue has room
  assign req_i.ready  = push_ready_i;
  assign push_valid_o = req_i.valid;

  // Decode and bring operands below p
  always_comb begin
    push_item_o.op = action_e'(req_i.action);
    push_item_o.a  = reduce_once({req_i.a_limb3, req_i.a_limb2, req_i.a_limb1, req_i.a_limb0});
    push_item_o.b  = reduce_once({req_i.b_limb3, req_i.b_limb2, req_i.b_limb1, req_i.b_limb0});
  end

endmodule

[src/pfa_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue between front end and execution back end.
// Depends on pfa_pkg.
module pfa_queue import pfa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t push_item_i,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  output item_t pop_item_o,
  output logic  pop_valid_o,
  input  logic  pop_ready_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[src/pfa_back.sv]
`timescale 1ns / 1ps
// Back end: sequenced multiplier, folding reduction, inversion ladder, result register.
// Depends on pfa_pkg and pfa_rsp_if.
module pfa_back import pfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  item_t     item_i,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  pfa_rsp_if.source rsp_o
);

  back_state_e  state_q, state_d;
  logic [3:0]   cnt_q, cnt_d;
  logic [7:0]   ibit_q, ibit_d;
  logic         phase_q, phase_d;
  logic         out_valid_q, out_valid_d;
  action_e      op_q, op_d;
  logic [255:0] x_q, x_d, y_q, y_d, a_q, a_d, res_q, res_d;
  logic [287:0] acc_q, acc_d;
  logic [223:0] lo_q, lo_d;
  logic [511:0] v_q, v_d;
  logic [63:0]  prod_q [8];
  logic [63:0]  prod_d [8];
  logic [255:0] r_q;
  logic         zero_q;

  logic [31:0]  y_dig;
  logic [287:0] row;
  logic [287:0] acc_step;
  logic [223:0] lo_shift;
  logic [255:0] hi;
  logic [289:0] red_sum;
  logic [256:0] fin_diff;
  logic [255:0] fin_r;
  logic [256:0] sum_ab, dif_ab;
  logic         take_a, last_bit, out_free, load_out;

  // Partial products of one 32-bit multiplier digit against all multiplicand digits
  assign y_dig = y_q[{cnt_q[2:0], 5'b0} +: 32];
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      prod_d[j] = 64'(x_q[32*j +: 32]) * 64'(y_dig);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 8; j++) begin
      prod_q[j] <= prod_d[j];
    end
  end

  // Sum a row and fold it into the shifting accumulator
  assign row = {32'b0, prod_q[6], prod_q[4], prod_q[2], prod_q[0]}
             + {prod_q[7], prod_q[5], prod_q[3], prod_q[1], 32'b0};
  assign acc_step = (acc_q >> 32) + row;
  assign lo_shift = {acc_q[31:0], lo_q[223:32]};

  // Fold the upper half: 2^256 = 2^32 + 977 mod p
  assign hi = v_q[511:256];
  assign red_sum = 290'(v_q[255:0]) + (290'(hi) << 32)
                 + (290'(hi) << 9) + (290'(hi) << 8) + (290'(hi) << 7)
                 + (290'(hi) << 6) + (290'(hi) << 4) + 290'(hi);

  // Final conditional subtraction
  assign fin_diff = {1'b0, v_q[255:0]} - {1'b0, PRIME};
  assign fin_r    = fin_diff[256] ? v_q[255:0] : fin_diff[255:0];

  assign sum_ab = {1'b0, item_i.a} + {1'b0, item_i.b};
  assign dif_ab = {1'b0, item_i.a} + ({1'b0, PRIME} - {1'b0, item_i.b});

  assign take_a   = !phase_q && INV_EXP[ibit_q];
  assign last_bit = (ibit_q == 8'd0);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign load_out = (state_q == ST_DONE) && out_free;
  assign item_ready_o = (state_q == ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = (item_i.op inside {ACT_MUL, ACT_INV}) ? ST_MUL : ST_RED;
        end
      end
      ST_MUL: begin
        if (cnt_q == 4'd8) begin
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        if (hi == 256'd0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (op_q == ACT_INV && (take_a || !last_bit)) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    a_d = a_q;
    op_d = op_q;
    v_d = v_q;
    acc_d = acc_q;
    lo_d = lo_q;
    cnt_d = cnt_q;
    ibit_d = ibit_q;
    phase_d = phase_q;
    res_d = res_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          op_d  = item_i.op;
          a_d   = item_i.a;
          cnt_d = 4'd0;
          case (item_i.op)
            ACT_ADD: v_d = {255'b0, sum_ab};
            ACT_SUB: v_d = {255'b0, dif_ab};
            ACT_MUL: begin
              x_d = item_i.a;
              y_d = item_i.b;
            end
            default: begin
              x_d     = FIELD_ONE;
              y_d     = FIELD_ONE;
              ibit_d  = 8'd255;
              phase_d = 1'b0;
            end
          endcase
        end
      end
      ST_MUL: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd0) begin
          acc_d = '0;
          lo_d  = '0;
        end else begin
          acc_d = acc_step;
          lo_d  = lo_shift;
        end
        if (cnt_q == 4'd8) begin
          v_d = {acc_step, lo_shift};
        end
      end
      ST_RED: begin
        v_d = {222'b0, red_sum};
      end
      ST_FIN: begin
        cnt_d = 4'd0;
        res_d = fin_r;
        x_d   = fin_r;
        if (op_q == ACT_INV) begin
          if (take_a) begin
            phase_d = 1'b1;
            y_d     = a_q;
          end else if (!last_bit) begin
            phase_d = 1'b0;
            ibit_d  = ibit_q - 8'd1;
            y_d     = fin_r;
          end
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 4'd0;
      ibit_q      <= 8'd0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ibit_q      <= ibit_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    a_q   <= a_d;
    op_q  <= op_d;
    v_q   <= v_d;
    acc_q <= acc_d;
    lo_q  <= lo_d;
    res_q <= res_d;
    if (load_out) begin
      r_q    <= res_q;
      zero_q <= (res_q == 256'd0);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.r_limb0     = r_q[63:0];
  assign rsp_o.r_limb1     = r_q[127:64];
  assign rsp_o.r_limb2     = r_q[191:128];
  assign rsp_o.r_limb3     = r_q[255:192];
  assign rsp_o.result_zero = zero_q;

endmodule

[src/pfa_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the result channel of the prime field arithmetic unit.
// Depends on pfa_pkg; bound to prime_field_arith_unit.
module pfa_checker import pfa_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [63:0] r_limb0_i,
  input logic [63:0] r_limb1_i,
  input logic [63:0] r_limb2_i,
  input logic [63:0] r_limb3_i,
  input logic        result_zero_i
);

  // Hold a stalled result: valid stays high and limbs 0 and 3 stay unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(r_limb0_i) && $stable(r_limb3_i))
    else $error("stalled result changed");

  // Zero flag agrees with the limbs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> result_zero_i == ((r_limb0_i | r_limb1_i | r_limb2_i | r_limb3_i) == 64'd0))
    else $error("zero flag mismatch");

  // Result fully reduced below p
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(r_limb3_i == LIMB_ONES && r_limb2_i == LIMB_ONES &&
                      r_limb1_i == LIMB_ONES && r_limb0_i >= PRIME_L0))
    else $error("result not reduced");

endmodule

bind prime_field_arith_unit pfa_checker u_pfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .r_limb0_i     (rsp_o.r_limb0),
  .r_limb1_i     (rsp_o.r_limb1),
  .r_limb2_i     (rsp_o.r_limb2),
  .r_limb3_i     (rsp_o.r_limb3),
  .result_zero_i (rsp_o.result_zero)
);

[tb/prime_field_arith_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for prime_field_arith_unit: directed and random requests,
// predicted with wide modular arithmetic. Depends on pfa_pkg, pfa_req_if, pfa_rsp_if.
module prime_field_arith_unit_tb;
  import pfa_pkg::*;

  typedef struct {
    action_e      op;
    logic [255:0] a;
    logic [255:0] b;
  } request_t;

  typedef struct {
    logic [255:0] value;
    logic         zero;
  } field_result_t;

  localparam int RANDOM_REQUESTS = 830;
  localparam int QUIET_TAIL      = 150;

  logic clk_i;
  logic rst_ni;

  pfa_req_if req();
  pfa_rsp_if rsp();

  prime_field_arith_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  request_t      pending_q[$];
  field_result_t expected_q[$];
  int            total_requests;
  int            sent_count;
  int            op_count[4];
  int            result_count;
  int            error_count;
  bit            req_taken;
  bit            stimulus_done;
  bit            pressure_done;
  int            send_gap;
  int            stall_left;
  int            hold_left;

  // Clock: 20 ns period
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Reduce a wide value modulo the field prime
  function automatic logic [255:0] mod_prime(input logic [511:0] x);
    logic [511:0] m;
    m = {256'd0, PRIME};
    return 256'(x % m);
  endfunction

  // a^(p-2) mod p by square-and-multiply, zero stays zero
  function automatic logic [255:0] field_inverse(input logic [255:0] x);
    logic [255:0] acc;
    acc = 256'd1;
    for (int i = 255; i >= 0; i--) begin
      acc = mod_prime({256'd0, acc} * {256'd0, acc});
      if (INV_EXP[i]) acc = mod_prime({256'd0, acc} * {256'd0, x});
    end
    return acc;
  endfunction

  // Expected reduced result of one request
  function automatic field_result_t field_op_result(input request_t r);
    field_result_t res;
    logic [255:0]  x;
    logic [255:0]  y;
    x = mod_prime({256'd0, r.a});
    y = mod_prime({256'd0, r.b});
    case (r.op)
      ACT_ADD: res.value = mod_prime({256'd0, x} + {256'd0, y});
      ACT_SUB: res.value = mod_prime({256'd0, x} + {256'd0, PRIME} - {256'd0, y});
      ACT_MUL: res.value = mod_prime({256'd0, x} * {256'd0, y});
      default: res.value = field_inverse(x);
    endcase
    res.zero = (res.value == 256'd0);
    return res;
  endfunction

  // Random operand biased towards the interesting corners of the field
  function automatic logic [255:0] random_operand();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    case ($urandom_range(0, 9))
      0: v = PRIME - 256'($urandom_range(0, 40));
      1: v = PRIME + 256'($urandom_range(0, 1200));
      2: v = 256'($urandom);
      3: v = ~256'($urandom_range(0, 5));
      default: ;
    endcase
    return v;
  endfunction

  function automatic request_t make_request(input action_e op, input logic [255:0] a,
                                            input logic [255:0] b);
    request_t r;
    r.op = op;
    r.a  = a;
    r.b  = b;
    return r;
  endfunction

  // Fill the request queue: corners first, then random traffic
  initial begin
    logic [255:0] corner[6];
    request_t     r;
    int           pick;
    req.valid   = 1'b0;
    req.action  = ACT_ADD;
    req.a_limb0 = '0;
    req.a_limb1 = '0;
    req.a_limb2 = '0;
    req.a_limb3 = '0;
    req.b_limb0 = '0;
    req.b_limb1 = '0;
    req.b_limb2 = '0;
    req.b_limb3 = '0;
    rsp.ready   = 1'b0;
    rst_ni      = 1'b0;
    corner[0] = 256'd0;
    corner[1] = 256'd1;
    corner[2] = PRIME - 256'd1;
    corner[3] = PRIME;
    corner[4] = PRIME + 256'd1;
    corner[5] = '1;
    for (int i = 0; i < 4; i++) begin
      pending_q.push_back(make_request(ACT_ADD, corner[i + 2], corner[5 - i]));
      pending_q.push_back(make_request(ACT_SUB, corner[i], corner[5 - i]));
      pending_q.push_back(make_request(ACT_MUL, corner[i + 2], corner[5 - i]));
    end
    // Inverse of zero, of the modulus itself, of one, of p-1 and of all ones; b is don't-care
    pending_q.push_back(make_request(ACT_INV, corner[0], corner[5]));
    pending_q.push_back(make_request(ACT_INV, corner[3], corner[2]));
    pending_q.push_back(make_request(ACT_INV, corner[1], corner[0]));
    pending_q.push_back(make_request(ACT_INV, corner[2], corner[1]));
    pending_q.push_back(make_request(ACT_INV, corner[5], corner[1]));
    pending_q.push_back(make_request(ACT_SUB, corner[4], corner[1]));
    pending_q.push_back(make_request(ACT_ADD, corner[0], corner[0]));
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      r.op = (pick < 3) ? ACT_INV : (pick < 35) ? ACT_ADD : (pick < 67) ? ACT_SUB : ACT_MUL;
      r.a  = random_operand();
      r.b  = random_operand();
      pending_q.push_back(r);
    end
    total_requests = pending_q.size();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stimulus_done && expected_q.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("Covered %0d requests: add %0d, sub %0d, mul %0d, inv %0d; %0d results checked.",
             sent_count, op_count[ACT_ADD], op_count[ACT_SUB], op_count[ACT_MUL],
             op_count[ACT_INV], result_count);
    $display("Operands spanned zero, one, values near and above p, and all ones.");
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("prime_field_arith_unit_tb OK");
    end else begin
      $display("prime_field_arith_unit_tb NOT OK");
    end
    $finish;
  end

  // Record accepted requests and check results at the rising edge
  always @(posedge clk_i) begin
    field_result_t exp_r;
    logic [255:0]  got;
    request_t      taken;
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        taken.op = action_e'(req.action);
        taken.a  = {req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0};
        taken.b  = {req.b_limb3, req.b_limb2, req.b_limb1, req.b_limb0};
        expected_q.push_back(field_op_result(taken));
        op_count[taken.op]++;
        sent_count++;
        req_taken = 1'b1;
        if (sent_count == total_requests) stimulus_done = 1'b1;
        if (sent_count == 120 && !pressure_done) begin
          pressure_done = 1'b1;
          hold_left     = 80;
        end
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.r_limb3, rsp.r_limb2, rsp.r_limb1, rsp.r_limb0};
        result_count++;
        if (expected_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result %h zero=%b", $realtime, got, rsp.result_zero);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r.value) begin
            error_count++;
            $display("%0t: result expected %h actual %h", $realtime, exp_r.value, got);
          end
          if (rsp.result_zero !== exp_r.zero) begin
            error_count++;
            $display("%0t: zero flag expected %b actual %b", $realtime, exp_r.zero,
                     rsp.result_zero);
          end
        end
      end
    end
  end

  // Request driver: advance at the falling edge, idle in random bursts
  always @(negedge clk_i) begin
    request_t r;
    bit       quiet;
    if (rst_ni && (!req.valid || req_taken)) begin
      req_taken = 1'b0;
      quiet     = (sent_count >= total_requests - QUIET_TAIL);
      if (send_gap > 0 && !quiet) begin
        send_gap--;
        req.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        r = pending_q.pop_front();
        req.valid   <= 1'b1;
        req.action  <= r.op;
        req.a_limb0 <= r.a[63:0];
        req.a_limb1 <= r.a[127:64];
        req.a_limb2 <= r.a[191:128];
        req.a_limb3 <= r.a[255:192];
        req.b_limb0 <= r.b[63:0];
        req.b_limb1 <= r.b[127:64];
        req.b_limb2 <= r.b[191:128];
        req.b_limb3 <= r.b[255:192];
        send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall in random bursts, hold off once for a long stretch
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0 && sent_count < total_requests - QUIET_TAIL) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 6);
      end
    end
  end

  // Guard against a hang
  initial begin
    #(20ns * 4_000_000);
    $display("prime_field_arith_unit_tb NOT OK");
    $finish;
  end

endmodule
